FILE: sv/csp_pkg.sv
// Shared types and constants for the CSV cell splitter.
package csp_pkg;

   localparam int MAX_CELL_LEN = 64;
   localparam int MAX_LINE_LEN = 65536;
   localparam int MAX_COLUMNS = 64;

   localparam int POS_W = 16;
   localparam int COL_W = 7;
   localparam int ROW_W = 32;
   localparam int MASK_W = 64;
   localparam int MASK_IDX_W = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [POS_W-1:0] LINE_POS_MAX = POS_W'(MAX_LINE_LEN - 1);
   localparam logic [COL_W-1:0] COL_SAT = {COL_W{1'b1}};
   localparam logic [7:0] LINE_END = 8'd10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_QUOTE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEPARATOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRING_MASK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_HEADER = 3'd4;

   localparam logic KIND_CELL = 1'b0;
   localparam logic KIND_ROW_END = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_TOO_LONG = 2'd1,
      ERR_COLUMNS = 2'd2
   } csp_err_type;

   // One parsed item as it travels from the front to the back.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [POS_W-1:0] offset;
      logic [POS_W-1:0] length;
      logic kind;
      logic last;
   } csp_item_type;

   // Header control from the configuration port.
   typedef struct packed {
      logic load;
      logic value;
   } csp_hdr_type;

endpackage

FILE: sv/csp_front.sv
// Front end: takes one byte per transfer, tracks quoting and cell bounds.
module csp_front import csp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_accept,
   input  logic [7:0]         data_byte,
   input  logic               end_of_data,
   input  logic [7:0]         quote_char,
   input  logic [7:0]         separator_char,
   input  logic               skip_header,
   input  csp_hdr_type        hdr,
   output logic               item_valid,
   output csp_item_type       item
);

   logic             in_quotes_ff, in_quotes_in;
   logic             begins_quote_ff, begins_quote_in;
   logic [POS_W-1:0] line_pos_ff, line_pos_in;
   logic [POS_W-1:0] cell_base_ff, cell_base_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             header_pending_ff, header_pending_in;
   logic             started_ff, started_in;

   logic             at_start;
   logic             is_quote;
   logic [POS_W-1:0] pos_inc;

   always_comb begin
      at_start = (line_pos_ff == cell_base_ff);
      is_quote = (data_byte == quote_char);
      pos_inc = (line_pos_ff == LINE_POS_MAX) ? line_pos_ff : line_pos_ff + POS_W'(1);

      in_quotes_in = in_quotes_ff;
      begins_quote_in = begins_quote_ff;
      line_pos_in = line_pos_ff;
      cell_base_in = cell_base_ff;
      column_in = column_ff;
      row_in = row_ff;
      header_pending_in = header_pending_ff;
      started_in = started_ff;

      item_valid = 1'b0;
      item.row = row_ff;
      item.col = column_ff;
      item.offset = cell_base_ff;
      item.length = line_pos_ff - cell_base_ff;
      item.kind = KIND_CELL;
      item.last = 1'b0;

      if (in_accept) begin
         if (end_of_data || data_byte == LINE_END) begin
            // Close the open line; the header line and empty lines give nothing.
            if (!header_pending_ff && line_pos_ff != '0) begin
               item_valid = 1'b1;
               item.last = 1'b1;
               row_in = row_ff + ROW_W'(1);
               if (in_quotes_ff) begin
                  item.kind = KIND_ROW_END;
                  item.offset = '0;
                  item.length = '0;
               end
            end
            header_pending_in = 1'b0;
            in_quotes_in = 1'b0;
            begins_quote_in = 1'b0;
            line_pos_in = '0;
            cell_base_in = '0;
            column_in = '0;
            if (end_of_data) begin
               row_in = '0;
               header_pending_in = skip_header;
               started_in = 1'b0;
            end else begin
               started_in = 1'b1;
            end
         end else begin
            started_in = 1'b1;
            if (!header_pending_ff) begin
               if (at_start) begin
                  begins_quote_in = is_quote;
               end
               if (is_quote) begin
                  if (at_start || begins_quote_ff) begin
                     in_quotes_in = !in_quotes_ff;
                  end
               end else if (data_byte == separator_char && !in_quotes_ff) begin
                  item_valid = 1'b1;
                  if (column_ff != COL_SAT) begin
                     column_in = column_ff + COL_W'(1);
                  end
                  cell_base_in = pos_inc;
                  begins_quote_in = 1'b0;
               end
            end
            line_pos_in = pos_inc;
         end
      end else if (hdr.load && !started_ff) begin
         header_pending_in = hdr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff <= 1'b0;
         begins_quote_ff <= 1'b0;
         line_pos_ff <= '0;
         cell_base_ff <= '0;
         column_ff <= '0;
         row_ff <= '0;
         header_pending_ff <= 1'b1;
         started_ff <= 1'b0;
      end else begin
         in_quotes_ff <= in_quotes_in;
         begins_quote_ff <= begins_quote_in;
         line_pos_ff <= line_pos_in;
         cell_base_ff <= cell_base_in;
         column_ff <= column_in;
         row_ff <= row_in;
         header_pending_ff <= header_pending_in;
         started_ff <= started_in;
      end
   end

   // A cell never starts past the current line position.
   a_start_in_line: assert property (@(posedge clock) disable iff (reset)
      cell_base_ff <= line_pos_ff)
      else $error("cell start beyond line position");

   // Nothing is emitted while the header line is being dropped.
   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      header_pending_ff |-> !item_valid)
      else $error("item emitted during header line");

   // A row end item only comes from a line that ends inside quotes.
   a_row_end_quoted: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.kind == KIND_ROW_END) |-> in_quotes_ff)
      else $error("row end item outside quotes");

endmodule

FILE: sv/csp_queue.sv
// Short queue of parsed items between the front and back ends.
module csp_queue import csp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  csp_item_type push_item,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output csp_item_type head
);

   csp_item_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      full = (count_ff == QCNT_W'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head = entries_ff[rptr_ff];
      do_push = push && !full;
      do_pop = pop && not_empty;
      wptr_in = do_push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in = do_pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH)) |-> (wptr_ff == rptr_ff))
      else $error("queue pointers disagree with count");

endmodule

FILE: sv/csp_back.sv
// Back end: grades each item for errors and holds the result register.
module csp_back import csp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  csp_item_type      q_head,
   output logic              q_pop,
   input  logic [COL_W-1:0]  column_count,
   input  logic [MASK_W-1:0] string_column_mask,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ROW_W-1:0]  rsp_row_index,
   output logic [COL_W-1:0]  rsp_column_index,
   output logic [POS_W-1:0]  rsp_cell_offset,
   output logic [POS_W-1:0]  rsp_cell_length,
   output logic              rsp_item_kind,
   output logic              rsp_last_in_row,
   output logic [1:0]        rsp_error_code
);

   logic             valid_ff, valid_in;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] offset_ff;
   logic [POS_W-1:0] length_ff;
   logic             kind_ff;
   logic             last_ff;
   csp_err_type      err_ff, err_in;

   logic             string_col;
   logic             too_long;
   logic [COL_W-1:0] cells;

   always_comb begin
      q_pop = q_not_empty && (!valid_ff || !rsp_stall);
      valid_in = q_pop ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);

      string_col = (q_head.col < COL_W'(MAX_COLUMNS)) &&
                   string_column_mask[q_head.col[MASK_IDX_W-1:0]];
      too_long = string_col && (q_head.length >= POS_W'(MAX_CELL_LEN));
      cells = (q_head.col == COL_SAT) ? COL_SAT : q_head.col + COL_W'(1);
      col_in = (q_head.col > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : q_head.col;

      err_in = ERR_NONE;
      if (q_head.kind == KIND_ROW_END) begin
         // A row left open in quotes never got its last cell.
         if (q_head.col != column_count) begin
            err_in = ERR_COLUMNS;
         end
      end else if (too_long) begin
         err_in = ERR_TOO_LONG;
      end else if (q_head.last && cells != column_count) begin
         err_in = ERR_COLUMNS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         row_ff <= q_head.row;
         col_ff <= col_in;
         offset_ff <= q_head.offset;
         length_ff <= q_head.length;
         kind_ff <= q_head.kind;
         last_ff <= q_head.last;
         err_ff <= err_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_row_index = row_ff;
   assign rsp_column_index = col_ff;
   assign rsp_cell_offset = offset_ff;
   assign rsp_cell_length = length_ff;
   assign rsp_item_kind = kind_ff;
   assign rsp_last_in_row = last_ff;
   assign rsp_error_code = err_ff;

   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_ROW_END) |-> last_ff)
      else $error("row end item not marked last");

   a_row_end_empty: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_ROW_END) |-> (length_ff == '0 && err_ff != ERR_TOO_LONG))
      else $error("row end item carries a cell");

   a_column_sat: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (col_ff <= COL_W'(MAX_COLUMNS)))
      else $error("column index not saturated");

endmodule

FILE: sv/csv_cell_splitter_unit.sv
// Top level of the CSV cell splitter: configuration registers and the three stages.
//
// The splitter takes one text byte per transfer and gives at most one cell
// descriptor per byte; it sustains one byte per clock cycle while the queue
// has room. The front end updates the line state (quoting, cell start, column
// and row counts) for every byte, so a byte is taken in each cycle as long as
// the four-entry item queue has room; req_stall rises only when that queue is
// full. A descriptor reaches the rsp port through the queue write and then the
// result register, and a stalled result does not block the input until the
// queue fills. Configuration writes take effect at once and should be made
// while no bytes are in flight.
module csv_cell_splitter_unit import csp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_end_of_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ROW_W-1:0]     rsp_row_index,
   output logic [COL_W-1:0]     rsp_column_index,
   output logic [POS_W-1:0]     rsp_cell_offset,
   output logic [POS_W-1:0]     rsp_cell_length,
   output logic                 rsp_item_kind,
   output logic                 rsp_last_in_row,
   output logic [1:0]           rsp_error_code,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MASK_W-1:0]    csr_wdata
);

   logic [7:0]        quote_ff;
   logic [7:0]        separator_ff;
   logic [COL_W-1:0]  column_count_ff;
   logic [MASK_W-1:0] mask_ff;
   logic              skip_header_ff;

   csp_hdr_type       hdr;
   logic              in_accept;
   logic              item_valid;
   csp_item_type      item;
   logic              q_full;
   logic              q_not_empty;
   logic              q_pop;
   csp_item_type      q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= 8'd34;
         separator_ff <= 8'd44;
         column_count_ff <= COL_W'(1);
         mask_ff <= '0;
         skip_header_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_QUOTE: begin
               quote_ff <= csr_wdata[7:0];
            end
            REG_SEPARATOR: begin
               separator_ff <= csr_wdata[7:0];
            end
            REG_COLUMN_COUNT: begin
               column_count_ff <= csr_wdata[COL_W-1:0];
            end
            REG_STRING_MASK: begin
               mask_ff <= csr_wdata;
            end
            REG_SKIP_HEADER: begin
               skip_header_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      hdr.load = csr_we && (csr_index == REG_SKIP_HEADER);
      hdr.value = csr_wdata[0];
      req_stall = q_full;
      in_accept = req_valid && !q_full;
   end

   csp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_accept      (in_accept),
      .data_byte      (req_data_byte),
      .end_of_data    (req_end_of_data),
      .quote_char     (quote_ff),
      .separator_char (separator_ff),
      .skip_header    (skip_header_ff),
      .hdr            (hdr),
      .item_valid     (item_valid),
      .item           (item)
   );

   csp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_valid),
      .push_item (item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   csp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .column_count       (column_count_ff),
      .string_column_mask (mask_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_row_index      (rsp_row_index),
      .rsp_column_index   (rsp_column_index),
      .rsp_cell_offset    (rsp_cell_offset),
      .rsp_cell_length    (rsp_cell_length),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_last_in_row    (rsp_last_in_row),
      .rsp_error_code     (rsp_error_code)
   );

endmodule

FILE: test/tb.sv
// Self-checking testbench for the CSV cell splitter: random and directed byte streams.
`timescale 1ns / 1ps

module tb;
   import csp_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int HOLD_OFF_DELAY = 200;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct {
      logic [7:0] data;
      logic       eod;
      bit         quick;
   } text_item_type;

   typedef struct {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [POS_W-1:0] offset;
      logic [POS_W-1:0] length;
      logic             kind;
      logic             last;
      csp_err_type      err;
   } cell_desc_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_data_byte = 8'h00;
   logic                 req_end_of_data = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ROW_W-1:0]     rsp_row_index;
   logic [COL_W-1:0]     rsp_column_index;
   logic [POS_W-1:0]     rsp_cell_offset;
   logic [POS_W-1:0]     rsp_cell_length;
   logic                 rsp_item_kind;
   logic                 rsp_last_in_row;
   logic [1:0]           rsp_error_code;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MASK_W-1:0]    csr_wdata = '0;

   csv_cell_splitter_unit uut (.*);

   always #5 clock = ~clock;

   // Shadow copy of the configuration registers.
   logic [7:0]        cfg_quote;
   logic [7:0]        cfg_sep;
   int                cfg_cols;
   logic [MASK_W-1:0] cfg_mask;
   logic              cfg_skip;

   // Shadow copy of the line parser state.
   bit               quoted_mode;
   bit               cell_opens_quoted;
   int               line_pos;
   int               cell_base;
   int               col_seen;
   logic [ROW_W-1:0] row_cnt;
   bit               hdr_pending;
   bit               stream_on;

   text_item_type byte_q[$];
   cell_desc_type desc_q[$];

   int queued_count = 0;
   int bytes_taken = 0;
   int desc_checked = 0;
   int rows_closed = 0;
   int long_flags = 0;
   int column_flags = 0;
   int quoted_ends = 0;
   int fail_count = 0;
   int cycle_count = 0;

   // Driver and monitor working variables.
   text_item_type next_item;
   bit            cur_quick = 0;
   bit            send_burst = 0;
   bit            recv_burst = 0;
   bit            send_busy;
   bit            got_desc;
   cell_desc_type new_desc;
   cell_desc_type want_desc;
   int            send_gap = 0;
   int            recv_hold = 0;

   bit hold_off_arm = 0;
   bit hold_off_done = 0;
   int hold_off_wait = 0;
   int hold_off_left = 0;

   function automatic int sat_pos(input int p);
      return (p > MAX_LINE_LEN - 1) ? MAX_LINE_LEN - 1 : p;
   endfunction

   function automatic int sat_col();
      return (col_seen > MAX_COLUMNS) ? MAX_COLUMNS : col_seen;
   endfunction

   // Only the first MAX_COLUMNS columns can be string typed.
   function automatic bit long_cell(input int len);
      if (col_seen >= MAX_COLUMNS) return 0;
      return cfg_mask[col_seen] && (len >= MAX_CELL_LEN);
   endfunction

   function automatic cell_desc_type make_desc(input int col, input int off, input int len,
                                               input logic kind, input logic last,
                                               input csp_err_type err);
      cell_desc_type d;
      d.row = row_cnt;
      d.col = COL_W'(col);
      d.offset = POS_W'(off);
      d.length = POS_W'(len);
      d.kind = kind;
      d.last = last;
      d.err = err;
      return d;
   endfunction

   task automatic close_line(output bit got, output cell_desc_type d);
      int len;
      int cells;
      csp_err_type err;
      got = 0;
      if (hdr_pending) begin
         hdr_pending = 0;
      end else if (line_pos > 0) begin
         if (!quoted_mode) begin
            len = line_pos - cell_base;
            err = long_cell(len) ? ERR_TOO_LONG : ERR_NONE;
            cells = (col_seen < 127) ? col_seen + 1 : 127;
            // A too-long last cell takes priority over a column count error.
            if (err == ERR_NONE && cells != cfg_cols) err = ERR_COLUMNS;
            d = make_desc(sat_col(), cell_base, len, KIND_CELL, 1'b1, err);
         end else begin
            d = make_desc(sat_col(), 0, 0, KIND_ROW_END, 1'b1,
                          (col_seen != cfg_cols) ? ERR_COLUMNS : ERR_NONE);
         end
         row_cnt = row_cnt + 1;
         got = 1;
      end
      quoted_mode = 0;
      cell_opens_quoted = 0;
      line_pos = 0;
      cell_base = 0;
      col_seen = 0;
   endtask

   // Advances the shadow parser by one accepted byte.
   task automatic split_byte(input logic [7:0] b, input logic eod,
                             output bit got, output cell_desc_type d);
      int pos;
      got = 0;
      if (eod) begin
         close_line(got, d);
         row_cnt = '0;
         hdr_pending = cfg_skip;
         stream_on = 0;
      end else begin
         stream_on = 1;
         if (b == LINE_END) begin
            close_line(got, d);
         end else begin
            if (!hdr_pending) begin
               pos = line_pos;
               if (pos == cell_base) cell_opens_quoted = (b == cfg_quote);
               if (b == cfg_quote) begin
                  if (pos == cell_base || cell_opens_quoted) quoted_mode = !quoted_mode;
               end else if (b == cfg_sep && !quoted_mode) begin
                  d = make_desc(sat_col(), cell_base, pos - cell_base, KIND_CELL, 1'b0,
                                long_cell(pos - cell_base) ? ERR_TOO_LONG : ERR_NONE);
                  got = 1;
                  if (col_seen < 127) col_seen++;
                  cell_base = sat_pos(pos + 1);
                  cell_opens_quoted = 0;
               end
            end
            line_pos = sat_pos(line_pos + 1);
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
   endtask

   task automatic push_byte(input logic [7:0] b, input logic eod, input bit quick);
      text_item_type it;
      it.data = b;
      it.eod = eod;
      it.quick = quick;
      byte_q = {byte_q, it};
      queued_count++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0, 1'b0);
   endtask

   function automatic logic [7:0] filler();
      logic [7:0] v;
      do v = 8'($urandom_range(32, 126)); while (v == cfg_quote || v == cfg_sep);
      return v;
   endfunction

   task automatic wait_idle();
      while (!(byte_q.size() == 0 && !req_valid && desc_q.size() == 0)) @(negedge clock);
      // Bytes that close no cell may still be in the pipeline.
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_QUOTE: cfg_quote = val[7:0];
         REG_SEPARATOR: cfg_sep = val[7:0];
         REG_COLUMN_COUNT: cfg_cols = int'(val[COL_W-1:0]);
         REG_STRING_MASK: cfg_mask = val;
         REG_SKIP_HEADER: begin
            cfg_skip = val[0];
            if (!stream_on) hdr_pending = val[0];
         end
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] q, input logic [7:0] s, input int cols,
                            input logic [MASK_W-1:0] mask, input logic skip);
      wait_idle();
      write_reg(REG_QUOTE, MASK_W'(q));
      write_reg(REG_SEPARATOR, MASK_W'(s));
      write_reg(REG_COLUMN_COUNT, MASK_W'(cols));
      write_reg(REG_STRING_MASK, mask);
      write_reg(REG_SKIP_HEADER, MASK_W'(skip));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly well-formed rows with random content, mixed with empty lines,
   // stream ends and raw noise.
   task automatic push_random(input int n_items, input bit end_eod);
      int stop_at;
      int r;
      int n_cells;
      int kind;
      int len;
      stop_at = queued_count + n_items;
      while (queued_count < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            push_byte(LINE_END, 1'b0, 1'b0);
         end else if (r < 7) begin
            push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end else if (r < 12) begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            if ($urandom_range(0, 1)) push_byte(LINE_END, 1'b0, 1'b0);
         end else begin
            n_cells = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cfg_cols + 2) : cfg_cols;
            for (int c = 0; c < n_cells; c++) begin
               if (c > 0) push_byte(cfg_sep, 1'b0, 1'b0);
               kind = $urandom_range(0, 99);
               if (kind < 55) begin
                  repeat ($urandom_range(0, 4)) push_byte(filler(), 1'b0, 1'b0);
               end else if (kind < 75) begin
                  push_byte(cfg_quote, 1'b0, 1'b0);
                  len = $urandom_range(0, 4);
                  repeat (len) begin
                     case ($urandom_range(0, 5))
                        0: push_byte(cfg_sep, 1'b0, 1'b0);
                        1: begin
                           push_byte(cfg_quote, 1'b0, 1'b0);
                           push_byte(cfg_quote, 1'b0, 1'b0);
                        end
                        default: push_byte(filler(), 1'b0, 1'b0);
                     endcase
                  end
                  push_byte(cfg_quote, 1'b0, 1'b0);
                  if ($urandom_range(0, 4) == 0) push_byte(filler(), 1'b0, 1'b0);
               end else if (kind < 82) begin
                  if (cfg_cols <= 8 || $urandom_range(0, 9) == 0) len = $urandom_range(60, 70);
                  else len = 1;
                  repeat (len) push_byte(filler(), 1'b0, 1'b0);
               end else if (kind < 88) begin
                  push_byte(filler(), 1'b0, 1'b0);
                  push_byte(cfg_quote, 1'b0, 1'b0);
                  push_byte(filler(), 1'b0, 1'b0);
               end else if (kind < 92) begin
                  // Opens a quote that is never closed on this line.
                  push_byte(cfg_quote, 1'b0, 1'b0);
                  repeat ($urandom_range(0, 3)) push_byte(filler(), 1'b0, 1'b0);
               end else begin
                  repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(11, 255)), 1'b0, 1'b0);
               end
            end
            push_byte(LINE_END, 1'b0, 1'b0);
         end
      end
      if (end_eod) push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
   endtask

   // Driver: presents pending bytes with a random gap after each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         send_busy = 0;
         if (req_valid && !req_stall) begin
            split_byte(req_data_byte, req_end_of_data, got_desc, new_desc);
            if (got_desc) desc_q = {desc_q, new_desc};
            bytes_taken++;
            send_gap = (send_burst || cur_quick) ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
         end else begin
            send_busy = req_valid;
         end
         if (!send_busy) begin
            if (send_gap == 0 && byte_q.size() > 0) begin
               next_item = byte_q.pop_front();
               req_data_byte <= next_item.data;
               req_end_of_data <= next_item.eod;
               cur_quick = next_item.quick;
               req_valid <= 1'b1;
            end else begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (desc_q.size() == 0) begin
               report_mismatch($sformatf("unexpected descriptor row %0d col %0d off %0d",
                                         rsp_row_index, rsp_column_index, rsp_cell_offset));
            end else begin
               want_desc = desc_q.pop_front();
               if (rsp_row_index !== want_desc.row || rsp_column_index !== want_desc.col ||
                   rsp_cell_offset !== want_desc.offset ||
                   rsp_cell_length !== want_desc.length ||
                   rsp_item_kind !== want_desc.kind || rsp_last_in_row !== want_desc.last ||
                   rsp_error_code !== want_desc.err) begin
                  report_mismatch($sformatf(
                     "got %0d/%0d/%0d/%0d/%0b/%0b/%0d expected %0d/%0d/%0d/%0d/%0b/%0b/%0d",
                     rsp_row_index, rsp_column_index, rsp_cell_offset, rsp_cell_length,
                     rsp_item_kind, rsp_last_in_row, rsp_error_code,
                     want_desc.row, want_desc.col, want_desc.offset, want_desc.length,
                     want_desc.kind, want_desc.last, want_desc.err));
               end
               desc_checked++;
               if (want_desc.last) rows_closed++;
               if (want_desc.err == ERR_TOO_LONG) long_flags++;
               if (want_desc.err == ERR_COLUMNS) column_flags++;
               if (want_desc.kind == KIND_ROW_END) quoted_ends++;
            end
            recv_hold = recv_burst ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 99) == 0) recv_burst = !recv_burst;
         end else if (recv_hold > 0) begin
            recv_hold--;
         end
         rsp_stall <= (recv_hold > 0) || (hold_off_left > 0);
      end
   end

   // Long receiver hold-off so that the item queue fills and the input stalls.
   always @(posedge clock) begin
      if (reset) begin
         hold_off_left <= 0;
      end else if (hold_off_arm && !hold_off_done) begin
         if (hold_off_wait < HOLD_OFF_DELAY) begin
            hold_off_wait <= hold_off_wait + 1;
         end else begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
         end
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d descriptors still expected",
                  cycle_count, desc_q.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      cfg_quote = 8'd34;
      cfg_sep = 8'd44;
      cfg_cols = 1;
      cfg_mask = '0;
      cfg_skip = 1'b1;
      quoted_mode = 0;
      cell_opens_quoted = 0;
      line_pos = 0;
      cell_base = 0;
      col_seen = 0;
      row_cnt = '0;
      hdr_pending = 1;
      stream_on = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: header, empty line, quoted separator, line ending quoted,
      // extreme bytes, a quote inside a plain cell, and a stream end on an open line.
      configure(8'd34, 8'd44, 3, 64'h5, 1'b1);
      push_text("h\n");
      push_text("\n");
      push_text("a,\"x,y\",\n");
      push_text("\"q\n");
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(LINE_END, 1'b0, 1'b0);
      push_text("b\"c,,\n");
      push_text("z");
      push_byte(8'h00, 1'b1, 1'b0);

      configure(8'd34, 8'd44, 3, 64'h5, 1'b1);
      hold_off_arm = 1;
      push_random(250, 1'b1);

      configure(8'd39, 8'd59, 1, 64'h0, 1'b0);
      push_random(150, 1'b1);

      // Widest rows: every column string typed, including a long cell past the last column.
      configure(8'd255, 8'd0, MAX_COLUMNS, '1, 1'b1);
      push_random(150, 1'b0);
      repeat (MAX_COLUMNS + 1) push_byte(cfg_sep, 1'b0, 1'b0);
      repeat (70) push_byte(filler(), 1'b0, 1'b0);
      push_byte(LINE_END, 1'b0, 1'b0);
      push_byte(8'h00, 1'b1, 1'b0);

      // Quote and separator share one byte value.
      configure(8'd59, 8'd59, 2, {$urandom, $urandom}, 1'b1);
      push_random(150, 1'b1);

      // Quote is the line end byte; the stream is left open for the next phase.
      configure(LINE_END, 8'd9, 2, 64'h2, 1'b0);
      push_random(120, 1'b0);

      // Separator is the line end byte; skip_header is written after the stream started.
      configure(8'd34, LINE_END, 3, '1, 1'b1);
      push_random(120, 1'b1);

      repeat (3) begin
         configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 3) == 0) ? MAX_COLUMNS : $urandom_range(1, 6),
                   {$urandom, $urandom}, 1'($urandom_range(0, 1)));
         push_random(100, 1'($urandom_range(0, 1)));
      end

      // One line sent back to back, with no gap between its bytes.
      configure(8'd34, 8'd44, 2, 64'h0, 1'b0);
      repeat (60) push_byte("a", 1'b0, 1'b1);
      push_byte(cfg_sep, 1'b0, 1'b1);
      repeat (10) push_byte("b", 1'b0, 1'b1);
      push_byte(cfg_sep, 1'b0, 1'b1);
      push_byte(LINE_END, 1'b0, 1'b1);
      push_byte(8'h00, 1'b1, 1'b0);

      wait_idle();
      repeat (20) @(posedge clock);
      if (desc_q.size() != 0)
         report_mismatch($sformatf("%0d descriptors never arrived", desc_q.size()));

      $display("sent %0d bytes under eleven register setups; checked %0d descriptors closing %0d rows",
               bytes_taken, desc_checked, rows_closed);
      $display("flags seen: %0d too long, %0d column count, %0d row ends inside quotes",
               long_flags, column_flags, quoted_ends);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
